// ===== rtl/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg
// Types, codes and constants shared by the pump run controller.
// ----------------------------------------------------------------------------
package prc_pkg;

  // Width of the internal time arithmetic; now_seconds is cut or widened to it
  localparam int unsigned TimeBits = 32;

  localparam int unsigned NowW    = 32;
  localparam int unsigned TempW   = 8;
  localparam int unsigned PeriodW = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;

  typedef logic [TimeBits-1:0]       time_t;
  typedef logic [PeriodW-1:0]        period_t;
  typedef logic signed [TempW-1:0]   temp_t;

  typedef enum logic [1:0] {
    CmdIdle  = 2'd0,
    CmdLow   = 2'd1,
    CmdFull  = 2'd2,
    CmdSpare = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RsnStopped = 2'd0,
    RsnTower   = 2'd1,
    RsnSilence = 2'd2,
    RsnCold    = 2'd3
  } reason_e;

  typedef enum logic [2:0] {
    ActNone    = 3'd0,
    ActStarted = 3'd1,
    ActStopped = 3'd2,
    ActRefused = 3'd3,
    ActIgnored = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    RplNone = 2'd0,
    RplLow  = 2'd1,
    RplHigh = 2'd2
  } reply_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSilenceStart = 3'd0,
    CfgRunLimit     = 3'd1,
    CfgColdInterval = 3'd2,
    CfgColdRunTime  = 3'd3,
    CfgColdThresh   = 3'd4
  } cfg_idx_e;

  localparam period_t SilenceStartRst = 24'd86400;  // one day
  localparam period_t RunLimitRst     = 24'd10800;  // three hours
  localparam period_t ColdIntervalRst = 24'd10800;
  localparam period_t ColdRunTimeRst  = 24'd600;    // ten minutes
  localparam temp_t   ColdThreshRst   = -8'sd5;

  // One poll as held in the input register
  typedef struct packed {
    cmd_e               command;
    logic [NowW-1:0]    now_seconds;
    temp_t              temperature;
  } poll_t;

  // One result as held in the output register
  typedef struct packed {
    logic    motor_on;
    reason_e run_reason;
    action_e action;
    reply_e  reply;
  } result_t;

endpackage

// ===== rtl/prc_if.sv =====
// ----------------------------------------------------------------------------
// prc_if
// Handshake channels of the pump run controller: polls, results, config.
// ----------------------------------------------------------------------------
interface prc_poll_if;
  import prc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic [NowW-1:0]         now_seconds;
  logic signed [TempW-1:0] temperature;

  modport source (output valid, command, now_seconds, temperature, input ready);
  modport sink   (input valid, command, now_seconds, temperature, output ready);
endinterface

interface prc_result_if;
  logic       valid;
  logic       ready;
  logic       motor_on;
  logic [1:0] run_reason;
  logic [2:0] action;
  logic [1:0] reply;

  modport source (output valid, motor_on, run_reason, action, reply, input ready);
  modport sink   (input valid, motor_on, run_reason, action, reply, output ready);
endinterface

interface prc_cfg_if;
  import prc_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/pump_run_controller_top.sv =====
// ----------------------------------------------------------------------------
// pump_run_controller_top
// Pump run controller: one poll in, one result out, run state kept inside.
// ----------------------------------------------------------------------------
// Usage
//   poll_i   : one request per poll (command, now_seconds, temperature).
//   result_o : one request per poll (motor_on, run_reason, action, reply),
//              in poll order.
//   cfg_i    : register writes, index 0..4 (silence start, run limit, cold
//              interval, cold run time, cold threshold); always ready.
//              Unknown indexes are dropped. Write only while idle.
// An accepted poll sits in the input register; the decision logic then loads
// the result register and the run state together at the same edge, so
// back-to-back polls see each other's effects. Throughput is one poll per
// cycle while result_o is not stalled.
// When result_o stalls, the result register holds and an empty input register
// still takes one more poll; poll_i.ready then drops until the stall clears.
// Reset puts the pump stopped, both time marks to zero and the registers
// to their defaults.
// ----------------------------------------------------------------------------
module pump_run_controller_top (
  input  logic clk_i,
  input  logic rst_ni,
  prc_poll_if.sink     poll_i,
  prc_cfg_if.sink      cfg_i,
  prc_result_if.source result_o
);
  import prc_pkg::*;

  // configuration
  period_t silence_start_q, run_limit_q, cold_interval_q, cold_run_time_q;
  temp_t   cold_thresh_q;

  // pipeline
  logic    in_valid_q, out_valid_q, advance;
  poll_t   in_q;
  result_t out_q, out_d;

  // run state
  reason_e reason_q, reason_d;
  time_t   last_stop_q, last_stop_d;
  time_t   deadline_q, deadline_d;

  // decision signals
  time_t   now, since_stop;
  logic    stopped, may_start;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silence_start_q <= SilenceStartRst;
      run_limit_q     <= RunLimitRst;
      cold_interval_q <= ColdIntervalRst;
      cold_run_time_q <= ColdRunTimeRst;
      cold_thresh_q   <= ColdThreshRst;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgSilenceStart: silence_start_q <= cfg_i.data;
        CfgRunLimit:     run_limit_q     <= cfg_i.data;
        CfgColdInterval: cold_interval_q <= cfg_i.data;
        CfgColdRunTime:  cold_run_time_q <= cfg_i.data;
        CfgColdThresh:   cold_thresh_q   <= cfg_i.data[TempW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance      = !out_valid_q || result_o.ready;
  assign poll_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (poll_i.ready) begin
      in_valid_q <= poll_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_i.ready && poll_i.valid) begin
      in_q.command     <= cmd_e'(poll_i.command);
      in_q.now_seconds <= poll_i.now_seconds;
      in_q.temperature <= poll_i.temperature;
    end
  end

  // decision logic
  assign now        = TimeBits'(in_q.now_seconds);
  assign since_stop = now - last_stop_q;
  assign stopped    = (reason_q == RsnStopped);

  always_comb begin
    reason_d    = reason_q;
    last_stop_d = last_stop_q;
    deadline_d  = deadline_q;
    out_d.action = ActNone;
    out_d.reply  = RplNone;
    may_start    = stopped || (reason_q == RsnCold);  // tower start overrides cold

    case (in_q.command)
      CmdLow: begin
        out_d.reply = RplLow;
        if (may_start) begin
          reason_d     = RsnTower;
          deadline_d   = now + TimeBits'(run_limit_q);
          out_d.action = ActStarted;
        end else begin
          out_d.action = ActRefused;
        end
      end
      CmdFull: begin
        out_d.reply = RplHigh;
        if (reason_q == RsnCold) begin
          out_d.action = ActIgnored;
        end else begin
          out_d.action = ActStopped;
          if (!stopped) begin
            reason_d    = RsnStopped;
            last_stop_d = now;
          end
        end
      end
      default: begin
        if (stopped && since_stop > TimeBits'(silence_start_q)) begin
          reason_d     = RsnSilence;
          deadline_d   = now + TimeBits'(run_limit_q);
          out_d.action = ActStarted;
        end else if (!stopped && now > deadline_q) begin
          reason_d     = RsnStopped;
          last_stop_d  = now;
          out_d.action = ActStopped;
        end else if (in_q.temperature < cold_thresh_q && stopped &&
                     since_stop > TimeBits'(cold_interval_q)) begin
          reason_d     = RsnCold;
          deadline_d   = now + TimeBits'(cold_run_time_q);
          out_d.action = ActStarted;
        end
      end
    endcase

    out_d.run_reason = reason_d;
    out_d.motor_on   = (reason_d != RsnStopped);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reason_q    <= RsnStopped;
      last_stop_q <= '0;
      deadline_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        reason_q    <= reason_d;
        last_stop_q <= last_stop_d;
        deadline_q  <= deadline_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.motor_on   = out_q.motor_on;
  assign result_o.run_reason = out_q.run_reason;
  assign result_o.action     = out_q.action;
  assign result_o.reply      = out_q.reply;

  // checks
  a_motor_matches_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.motor_on == (out_q.run_reason != RsnStopped)))
    else $error("motor level disagrees with run reason");

  a_started_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.action == ActStarted) |-> out_q.motor_on)
    else $error("start reported with motor off");

  a_full_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.reply == RplHigh && out_q.action != ActIgnored)
      |-> !out_q.motor_on)
    else $error("tower full left the motor running");

  a_poll_held_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !result_o.ready) |=> (in_valid_q && $stable(reason_q)))
    else $error("pending poll lost or state moved during stall");

endmodule

// ===== tb/sv/pump_run_controller_top_tb.sv =====
// ----------------------------------------------------------------------------
// pump_run_controller_top_tb
// Self-checking bench: directed polls from a table, then random polls under
// several register settings, each result checked against a local model of
// the run state or, for rows typed by hand, against the table's own values.
// ----------------------------------------------------------------------------
module pump_run_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prc_pkg::*;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned PerPhase   = 100;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned MaxReports = 10;

  typedef struct {
    cmd_e              cmd;
    logic [NowW-1:0]   now;
    temp_t             temp;
    bit                typed;   // want is filled in by hand
    result_t           want;
  } poll_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  prc_poll_if   poll ();
  prc_cfg_if    cfg ();
  prc_result_if res ();

  pump_run_controller_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .poll_i   (poll),
    .cfg_i    (cfg),
    .result_o (res)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Local copy of run state and registers
  reason_e st_reason;
  logic    st_motor;
  time_t   st_last_stop;
  time_t   st_deadline;
  period_t c_silence;
  period_t c_run;
  period_t c_cold_int;
  period_t c_cold_run;
  temp_t   c_thresh;

  poll_row_t   poll_q[$];
  result_t     outcome_q[$];
  int unsigned bad_count;
  int unsigned cycle_cnt;
  int unsigned snd_idle;
  int unsigned rcv_idle;

  poll_row_t dir_rows [19] = '{
    '{CmdIdle,  32'd0,          8'sd125,  1'b1, '{1'b0, RsnStopped, ActNone,    RplNone}},
    '{CmdFull,  32'd5,          8'sd0,    1'b1, '{1'b0, RsnStopped, ActStopped, RplHigh}},
    '{CmdSpare, 32'd10,         -8'sd55,  1'b1, '{1'b0, RsnStopped, ActNone,    RplNone}},
    '{CmdLow,   32'd100,        8'sd20,   1'b1, '{1'b1, RsnTower,   ActStarted, RplLow}},
    '{CmdLow,   32'd200,        8'sd20,   1'b1, '{1'b1, RsnTower,   ActRefused, RplLow}},
    '{CmdIdle,  32'd10900,      8'sd20,   1'b0, '0},
    '{CmdIdle,  32'd10901,      8'sd20,   1'b0, '0},
    '{CmdIdle,  32'd21702,      -8'sd6,   1'b0, '0},
    '{CmdFull,  32'd21800,      -8'sd6,   1'b0, '0},
    '{CmdLow,   32'd21900,      -8'sd6,   1'b0, '0},
    '{CmdFull,  32'd22000,      8'sd0,    1'b0, '0},
    '{CmdIdle,  32'd108401,     8'sd0,    1'b0, '0},
    '{CmdLow,   32'd108500,     8'sd0,    1'b0, '0},
    '{CmdIdle,  32'hFFFF_FFFF,  -8'sd55,  1'b0, '0},
    '{CmdIdle,  32'd10800,      -8'sd55,  1'b0, '0},
    '{CmdFull,  32'd11000,      -8'sd55,  1'b0, '0},
    '{CmdIdle,  32'd11401,      -8'sd55,  1'b0, '0},
    '{CmdLow,   32'hFFFF_F000,  8'sd0,    1'b0, '0},
    '{CmdIdle,  32'hFFFF_F001,  8'sd0,    1'b0, '0}
  };

  function automatic action_e start_run(reason_e want, time_t now, period_t dur);
    if (st_reason != RsnStopped && !(want != RsnCold && st_reason == RsnCold)) begin
      return ActRefused;
    end
    st_motor    = 1'b1;
    st_reason   = want;
    st_deadline = now + time_t'(dur);
    return ActStarted;
  endfunction

  function automatic action_e halt_pump(time_t now);
    st_motor = 1'b0;
    if (st_reason != RsnStopped) begin
      st_reason    = RsnStopped;
      st_last_stop = now;
    end
    return ActStopped;
  endfunction

  function automatic result_t pump_outcome(cmd_e cmd, logic [NowW-1:0] now_in, temp_t temp);
    time_t   now;
    time_t   since;
    action_e act;
    reply_e  rpl;
    result_t r;
    now   = time_t'(now_in);
    since = now - st_last_stop;
    act   = ActNone;
    rpl   = RplNone;
    if (cmd == CmdLow) begin
      rpl = RplLow;
      act = start_run(RsnTower, now, c_run);
    end else if (cmd == CmdFull) begin
      rpl = RplHigh;
      // a full tower cannot cut an anti-freeze run short
      if (st_reason == RsnCold) act = ActIgnored;
      else act = halt_pump(now);
    end else begin
      if (st_reason == RsnStopped && since > time_t'(c_silence)) begin
        act = start_run(RsnSilence, now, c_run);
      end else if (st_reason != RsnStopped && now > st_deadline) begin
        act = halt_pump(now);
      end else if (temp < c_thresh && st_reason == RsnStopped &&
                   since > time_t'(c_cold_int)) begin
        act = start_run(RsnCold, now, c_cold_run);
      end
    end
    r.motor_on   = st_motor;
    r.run_reason = st_reason;
    r.action     = act;
    r.reply      = rpl;
    return r;
  endfunction

  function automatic void store_setting(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
    case (cfg_idx_e'(idx))
      CfgSilenceStart: c_silence  = val;
      CfgRunLimit:     c_run      = val;
      CfgColdInterval: c_cold_int = val;
      CfgColdRunTime:  c_cold_run = val;
      CfgColdThresh:   c_thresh   = temp_t'(val[TempW-1:0]);
      default: ;
    endcase
  endfunction

  function automatic void check_outcome(result_t got, result_t want);
    if (got !== want) begin
      bad_count++;
      if (bad_count <= MaxReports) begin
        $display("mismatch: motor %0d/%0d reason %0d/%0d action %0d/%0d reply %0d/%0d (exp/got)",
                 want.motor_on, got.motor_on, want.run_reason, got.run_reason,
                 want.action, got.action, want.reply, got.reply);
      end
    end
  endfunction

  // Scoreboard: results are checked before this edge's poll is predicted
  always @(posedge clk_i) begin : monitor
    poll_row_t row;
    result_t   want;
    result_t   got;
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        got = result_t'({res.motor_on, res.run_reason, res.action, res.reply});
        if (outcome_q.size() == 0) begin
          bad_count++;
          if (bad_count <= MaxReports) $display("result with no poll outstanding: %0h", got);
        end else begin
          check_outcome(got, outcome_q.pop_front());
        end
      end
      if (cfg.valid && cfg.ready) store_setting(cfg.index, cfg.data);
      if (poll.valid && poll.ready) begin
        row  = poll_q.pop_front();
        want = pump_outcome(row.cmd, row.now, row.temp);
        if (row.typed) want = row.want;
        outcome_q.push_back(want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("pump_run_controller_top_tb failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    res.ready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  // Entered and left at a falling edge; valid stays high for the next poll
  task automatic send_poll(poll_row_t r);
    while ($urandom_range(0, 99) < snd_idle) begin
      poll.valid <= 1'b0;
      @(negedge clk_i);
    end
    poll.valid       <= 1'b1;
    poll.command     <= r.cmd;
    poll.now_seconds <= r.now;
    poll.temperature <= r.temp;
    poll_q.push_back(r);
    do @(posedge clk_i); while (!poll.ready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDatW-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
  endtask

  task automatic drain_polls();
    poll.valid <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apply_settings(int unsigned si, int unsigned rl, int unsigned ci,
                                int unsigned cr, int th);
    drain_polls();
    write_reg(CfgSilenceStart, si[CfgDatW-1:0]);
    write_reg(CfgRunLimit, rl[CfgDatW-1:0]);
    write_reg(CfgColdInterval, ci[CfgDatW-1:0]);
    write_reg(CfgColdRunTime, cr[CfgDatW-1:0]);
    write_reg(CfgColdThresh, CfgDatW'(th[TempW-1:0]));
    cfg.valid <= 1'b0;
  endtask

  initial begin : stimulus
    poll_row_t       row;
    logic [NowW-1:0] clock_s;
    int unsigned     scale;
    int unsigned     pick;
    int              thr;
    int              t;

    rst_ni           = 1'b0;
    poll.valid       = 1'b0;
    poll.command     = CmdIdle;
    poll.now_seconds = '0;
    poll.temperature = '0;
    cfg.valid        = 1'b0;
    cfg.index        = CfgSilenceStart;
    cfg.data         = '0;
    res.ready        = 1'b0;
    bad_count        = 0;
    cycle_cnt        = 0;
    snd_idle         = 33;
    rcv_idle         = 53;
    st_reason        = RsnStopped;
    st_motor         = 1'b0;
    st_last_stop     = '0;
    st_deadline      = '0;
    c_silence        = SilenceStartRst;
    c_run            = RunLimitRst;
    c_cold_int       = ColdIntervalRst;
    c_cold_run       = ColdRunTimeRst;
    c_thresh         = ColdThreshRst;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_poll(dir_rows[i]);

    clock_s = '0;
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin apply_settings(50, 20, 30, 10, 0); thr = 0; scale = 120; end
        1: begin apply_settings(0, 0, 0, 0, -55); thr = -55; scale = 4; end
        2: begin
          apply_settings(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 125);
          thr = 125; scale = 20_000_000;
        end
        3: begin
          thr = int'($urandom_range(0, 180)) - 55;
          apply_settings($urandom_range(0, 300), $urandom_range(0, 300),
                         $urandom_range(0, 300), $urandom_range(0, 300), thr);
          scale = 400;
        end
        4: begin
          thr = int'($urandom_range(0, 180)) - 55;
          apply_settings($urandom_range(0, 5000), $urandom_range(0, 5000),
                         $urandom_range(0, 5000), $urandom_range(0, 5000), thr);
          scale = 8000;
        end
        default: begin
          thr = 20;
          apply_settings($urandom_range(0, 1000), 24'hFF_FFFF, 0, 24'hFF_FFFF, thr);
          scale = 3000;
        end
      endcase
      // receiver-heavy idling, then sender-heavy, then flat out
      if (p < 2) begin
        snd_idle = 33; rcv_idle = 53;
      end else if (p < 4) begin
        snd_idle = 53; rcv_idle = 33;
      end else begin
        snd_idle = 0; rcv_idle = 0;
      end

      for (int n = 0; n < PerPhase; n++) begin
        case ($urandom_range(0, 15))
          0: clock_s = $urandom();
          1: clock_s = 32'hFFFF_FFFF - $urandom_range(0, scale);
          default: clock_s = clock_s + $urandom_range(0, scale);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 55)      row.cmd = CmdIdle;
        else if (pick < 72) row.cmd = CmdLow;
        else if (pick < 90) row.cmd = CmdFull;
        else                row.cmd = CmdSpare;
        // half the temperatures sit around the threshold
        if ($urandom_range(0, 1) == 0) t = int'($urandom_range(0, 180)) - 55;
        else t = thr + int'($urandom_range(0, 6)) - 3;
        if (t < -55) t = -55;
        if (t > 125) t = 125;
        row.now   = clock_s;
        row.temp  = temp_t'(t);
        row.typed = 1'b0;
        row.want  = '0;
        send_poll(row);
      end
    end

    drain_polls();
    repeat (8) @(posedge clk_i);
    if (bad_count == 0 && outcome_q.size() == 0) begin
      $display("pump_run_controller_top_tb passed");
    end else begin
      $display("pump_run_controller_top_tb failed");
    end
    $finish;
  end

endmodule
